### rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Shared types, codes and constants for the sorted priority queue and its cells.
// ----------------------------------------------------------------------------
package spq_pkg;

	localparam int DEPTH_DEF = 8;
	localparam int VAL_W     = 32;
	localparam int PRI_W     = 8;
	localparam int OCC_W     = 4;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_REMOVE = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef struct packed {
		op_t                     operation;
		logic signed [VAL_W-1:0] entry_value;
		logic        [PRI_W-1:0] entry_priority;
	} in_t;

	typedef struct packed {
		status_t                 status;
		logic signed [VAL_W-1:0] removed_value;
		logic        [PRI_W-1:0] removed_priority;
		logic        [OCC_W-1:0] occupancy;
	} out_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] value;
		logic        [PRI_W-1:0] prio;
	} entry_t;

	// Command broadcast to every cell of the chain at once.
	typedef struct packed {
		logic   shift_in;   // accepted insert into a queue with room
		logic   shift_out;  // accepted remove from a queue that holds entries
		entry_t entry;      // entry carried by the insert
	} cell_cmd_t;

endpackage

### rtl/spq_chan_if.sv
// ----------------------------------------------------------------------------
// Stream channel
// Valid/ready channel carrying one payload beat; a beat moves when both are high.
// ----------------------------------------------------------------------------
interface spq_chan_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

### rtl/spq_cell.sv
// ----------------------------------------------------------------------------
// Sorted priority queue cell
// One slot of the sorted chain; shifts toward the tail on insert, toward the head on remove.
// ----------------------------------------------------------------------------
module spq_cell (
	input  logic               clk,
	input  spq_pkg::cell_cmd_t cmd,
	input  logic               occupied,
	input  logic               prev_moves,
	input  spq_pkg::entry_t    prev_entry,
	input  spq_pkg::entry_t    next_entry,
	output logic               moves,
	output spq_pkg::entry_t    entry
);
	spq_pkg::entry_t entry_q;

	// A cell gives way when it is empty or holds a strictly lower priority, so
	// equal priorities stay ahead of the newcomer.
	assign moves = !occupied || (entry_q.prio < cmd.entry.prio);
	assign entry = entry_q;

	always_ff @(posedge clk) begin
		if (cmd.shift_in && moves) begin
			entry_q <= prev_moves ? prev_entry : cmd.entry;
		end else if (cmd.shift_out) begin
			entry_q <= next_entry;
		end
	end
endmodule

### rtl/sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// Sorted priority queue
// Bounded queue held in a chain of cells sorted by descending priority.
// ----------------------------------------------------------------------------
// The queue holds up to DEPTH entries, each a signed 32-bit value and an 8-bit
// priority, kept sorted with the highest priority in cell 0. Every command beat
// produces exactly one response beat. An insert lands behind every stored entry
// of greater or equal priority, so equal priorities leave in arrival order; an
// insert into a full queue is dropped with status FULL, and a remove from an
// empty queue returns status EMPTY. Removed value and priority are zero unless
// a remove succeeds, and occupancy reports the entry count after the command.
// For each command, all cells compare against the new priority and shift to
// their neighbor on the same edge, so a new command is taken in every cycle
// that is not stalled. The response sits in an output register, which lets
// the next command in while the previous response is being taken; the command
// side stalls only while a response waits and the response side is not ready.
// The response appears in the cycle after its command is accepted.
module sorted_priority_queue #(
	parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	spq_chan_if.sink    cmd,
	spq_chan_if.source  rsp
);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   count_next;
	logic               rsp_valid_q;
	spq_pkg::out_t      rsp_q;
	spq_pkg::in_t       req;
	spq_pkg::cell_cmd_t cell_cmd;
	logic               accept;
	logic               full;
	logic               empty;
	spq_pkg::status_t   status;

	spq_pkg::entry_t    entries [DEPTH];
	logic               moves   [DEPTH];

	assign req    = cmd.data;
	assign full   = (count_q == CNT_W'(DEPTH));
	assign empty  = (count_q == '0);

	// The response register frees up as soon as its beat is taken.
	assign cmd.ready = !rsp_valid_q || rsp.ready;
	assign accept    = cmd.valid && cmd.ready;

	always_comb begin
		cell_cmd.shift_in  = accept && (req.operation == spq_pkg::OP_INSERT) && !full;
		cell_cmd.shift_out = accept && (req.operation == spq_pkg::OP_REMOVE) && !empty;
		cell_cmd.entry.value = req.entry_value;
		cell_cmd.entry.prio  = req.entry_priority;

		if (req.operation == spq_pkg::OP_INSERT) begin
			status = full ? spq_pkg::ST_FULL : spq_pkg::ST_DONE;
		end else begin
			status = empty ? spq_pkg::ST_EMPTY : spq_pkg::ST_DONE;
		end

		count_next = count_q;
		if (cell_cmd.shift_in) begin
			count_next = count_q + CNT_W'(1);
		end else if (cell_cmd.shift_out) begin
			count_next = count_q - CNT_W'(1);
		end
	end

	// The chain: each cell looks at its neighbor toward the head when opening a
	// gap and at its neighbor toward the tail when closing one.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		localparam logic [CNT_W-1:0] IDX = CNT_W'(i);
		logic            prev_moves;
		spq_pkg::entry_t prev_entry;
		spq_pkg::entry_t next_entry;

		if (i == 0) begin : g_head
			assign prev_moves = 1'b0;
			assign prev_entry = '0;
		end else begin : g_body
			assign prev_moves = moves[i-1];
			assign prev_entry = entries[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign next_entry = '0;
		end else begin : g_inner
			assign next_entry = entries[i+1];
		end

		spq_cell u_cell (
			.clk        (clk),
			.cmd        (cell_cmd),
			.occupied   (IDX < count_q),
			.prev_moves (prev_moves),
			.prev_entry (prev_entry),
			.next_entry (next_entry),
			.moves      (moves[i]),
			.entry      (entries[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			count_q <= count_next;
			if (accept) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Response payload; the head entry is captured before the chain shifts.
	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q.status           <= status;
			rsp_q.removed_value    <= cell_cmd.shift_out ? entries[0].value : '0;
			rsp_q.removed_priority <= cell_cmd.shift_out ? entries[0].prio : '0;
			rsp_q.occupancy        <= spq_pkg::OCC_W'(count_next);
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

	// The count never passes the capacity.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
	else $error("entry count above capacity");

	// A successful insert grows the queue by exactly one entry.
	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		cell_cmd.shift_in |=> count_q == $past(count_q) + CNT_W'(1))
	else $error("insert did not grow the queue by one");

	// The two head cells stay in priority order whenever both are occupied.
	a_head_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q >= CNT_W'(2)) |-> entries[0].prio >= entries[1].prio)
	else $error("head cells out of priority order");

	// A rejected command reports zero for the removed fields.
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_q.status != spq_pkg::ST_DONE) |->
			(rsp_q.removed_value == '0 && rsp_q.removed_priority == '0))
	else $error("rejected command returned a nonzero entry");
endmodule
